// ===== hw/rtl/masked_crc32_byte_stream_macros.svh =====
// Assertion macros used by the checker file of the checksum block.
// Every macro samples on the rising clock edge and is disabled while
// the active-low reset is asserted.
`ifndef MASKED_CRC32_BYTE_STREAM_MACROS_SVH
`define MASKED_CRC32_BYTE_STREAM_MACROS_SVH

// A condition that must hold at every sampled edge.
`define MCRC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition seen at one edge implies a consequence at the next edge.
`define MCRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// A condition seen at one edge implies a consequence at the same edge.
`define MCRC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mcrc_pkg.sv =====
package mcrc_pkg;

    // Reflected CRC-32 polynomial, shifting right.
    localparam logic [31:0] CRC32_REFL_GEN = 32'hEDB88320;

    // Value of the byte mask register after reset.
    localparam logic [31:0] MASK_RESET = 32'hD202EF8D;

    localparam int BITS_PER_BYTE = 8;

    // One input item as it sits in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_message;
        logic       end_of_message;
    } stage_item_t;

    // One byte step of the reflected CRC: the low byte of the checksum,
    // mixed with the data, is run through eight shift-and-reduce steps and
    // then folded into the remaining upper bits.
    function automatic logic [31:0] crc_byte_step(input logic [31:0] crc,
                                                  input logic [7:0]  data);
        logic [31:0] r;
        r = {24'd0, crc[7:0] ^ data};
        for (int k = 0; k < BITS_PER_BYTE; k++)
        begin
            if (r[0])
            begin
                r = (r >> 1) ^ CRC32_REFL_GEN;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r ^ {8'd0, crc[31:8]};
    endfunction

endpackage

// ===== hw/rtl/mcrc_in_stage.sv =====
module mcrc_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 start_of_message,
    input  logic                 end_of_message,
    input  logic                 take,
    output logic                 item_valid,
    output mcrc_pkg::stage_item_t item
);
    import mcrc_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    stage_item_t item_reg;
    logic        load;

    // The register can take a new item when it is empty or when its
    // current item moves on in the same cycle.
    assign in_ready   = !valid_reg || take;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data_byte        <= data_byte;
            item_reg.start_of_message <= start_of_message;
            item_reg.end_of_message   <= end_of_message;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/mcrc_core.sv =====
module mcrc_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  mcrc_pkg::stage_item_t item,
    output logic                  take,
    input  logic                  mask_write,
    input  logic [31:0]           mask_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           running_crc,
    output logic                  message_done
);
    import mcrc_pkg::*;

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] mask_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] crc_reg;
    logic        done_reg;
    logic [31:0] acc_base;

    // The result register loads when empty or when its result is taken.
    assign take = item_valid && (!out_valid_reg || out_ready);

    // A start of message clears the running value before this byte.
    assign acc_base = item.start_of_message ? 32'd0 : acc_reg;
    assign acc_next = crc_byte_step(acc_base, item.data_byte) ^ mask_reg;

    assign out_valid_next = take ? 1'b1 : ((out_valid_reg && out_ready) ? 1'b0
                                                                        : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 32'd0;
            mask_reg      <= MASK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                acc_reg <= acc_next;
            end
            if (mask_write)
            begin
                mask_reg <= mask_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            crc_reg  <= acc_next;
            done_reg <= item.end_of_message;
        end
    end

    assign out_valid    = out_valid_reg;
    assign running_crc  = crc_reg;
    assign message_done = done_reg;

endmodule

// ===== hw/rtl/masked_crc32_byte_stream.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    data_byte, start_of_message, end_of_message
// result    out        out_valid/out_ready  running_crc, message_done
// config    in         cfg_valid/cfg_ready  byte_xor_mask
//
// Each item waits in the input register and is then folded into the checksum
// on its way into the result register, where its result is shown and can be
// taken. One item is accepted per cycle while the result side is not stalled;
// the combinational CRC byte step between the two registers allows that rate.
// Reset clears the running checksum to zero and loads the byte mask with
// its default. A stalled result holds while the input register still takes
// one more item; after that the input side waits as well.
module masked_crc32_byte_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_message,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] running_crc,
    output logic        message_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] byte_xor_mask
);
    import mcrc_pkg::*;

    logic        item_valid;
    stage_item_t item;
    logic        take;

    // The mask register accepts a write in every cycle.
    assign cfg_ready = 1'b1;

    // Input register: holds one accepted item until the core takes it.
    mcrc_in_stage u_in_stage (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .start_of_message (start_of_message),
        .end_of_message   (end_of_message),
        .take             (take),
        .item_valid       (item_valid),
        .item             (item)
    );

    // Core: the running checksum, the byte mask and the result register.
    // The checksum is updated in the same cycle the item enters the result
    // register, which keeps the items strictly in order.
    mcrc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .take         (take),
        .mask_write   (cfg_valid && cfg_ready),
        .mask_data    (byte_xor_mask),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .running_crc  (running_crc),
        .message_done (message_done)
    );

endmodule

// ===== hw/rtl/masked_crc32_byte_stream_checker.sv =====
`include "masked_crc32_byte_stream_macros.svh"

module masked_crc32_byte_stream_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] running_crc,
    input logic        message_done
);

    // Number of items accepted whose result has not yet been taken.
    logic [2:0] occ_reg;
    logic [2:0] occ_next;

    assign occ_next = occ_reg + {2'd0, in_valid && in_ready}
                              - {2'd0, out_valid && out_ready};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 3'd0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    `MCRC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `MCRC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(running_crc) && $stable(message_done), "result changed while stalled")
    `MCRC_ASSERT_SAME(a_no_invent, clk, rst_n, occ_reg == 3'd0, !out_valid, "result shown with no item in flight")
    `MCRC_ASSERT_ALWAYS(a_occ_bound, clk, rst_n, occ_reg <= 3'd2, "more than two items in flight")
    `MCRC_ASSERT_SAME(a_full_stall, clk, rst_n, (occ_reg == 3'd2) && !out_ready, !in_ready, "input taken while both registers are full")

endmodule

bind masked_crc32_byte_stream masked_crc32_byte_stream_checker u_checker (.*);
